// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// Depends on nothing; every macro samples on the rising clock edge with an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is low.
`define LPN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lpn assertion failed");

// Same-cycle implication built on the plain check.
`define LPN_IMPLY(lbl, clk, rstn, ante, cons) \
    `LPN_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

// ===== hw/rtl/lpn_pkg.sv =====
// Constants for the lexical path normalizer: characters, beat kinds, default sizes.
// No dependencies; imported by the top level and by its checker.
package lpn_pkg;

    localparam logic [7:0] SLASH_CH = 8'h2F;
    localparam logic [7:0] DOT_CH   = 8'h2E;

    localparam logic KIND_PATH = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int STORE_BYTES_DEF = 256;
    localparam int MAX_DEPTH_DEF   = 64;

endpackage

// ===== hw/rtl/lexical_path_normalizer_top.sv =====
// Lexical path normalizer: one path byte or one read request per input beat.
// Input channel s_*: s_kind selects a path byte (s_path_byte, s_last) or a read of the
// normalized path at s_read_index. Output channel m_*: one result beat per input beat,
// carrying the byte read (0 for path bytes or beyond the length), the current length,
// the done flag and the truncated flag.
// Throughput: one beat per cycle while s_ready holds (see the result queue below). Every path
// byte does at most one byte-store write, one flag update and at most one component-stack
// write or read; the single write port of each memory sets that figure.
// A beat accepted on s_* passes the read stage (the byte-store read register) and then the
// result queue before it shows on m_valid.
// A three-entry result queue sits behind the read stage; s_ready counts the queue fill plus
// the beat in the read stage, so it drops once three results wait on a stalled receiver.
// Reset clears the length, depth, flags and the queue; the byte store and the component
// stack keep their contents and need no clearing pass.
// A path byte that follows a finished path starts a new path.
module lexical_path_normalizer_top
    import lpn_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_DEPTH   = MAX_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_path_byte,
    input  logic       s_last,
    input  logic [7:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic [8:0] m_path_length,
    output logic       m_done_res,
    output logic       m_truncated
);

    localparam int WLW = $clog2(STORE_BYTES + 1);
    localparam int AW  = $clog2(STORE_BYTES);
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int SAW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW  = (WLW > 8) ? WLW : 8;

    localparam logic [WLW:0]   STORE_LIM = (WLW + 1)'(STORE_BYTES);
    localparam logic [DW-1:0]  DEPTH_LIM = DW'(MAX_DEPTH);

    typedef struct packed {
        logic [7:0] read_byte;
        logic [8:0] path_length;
        logic       done_res;
        logic       truncated;
    } result_t;

    // Byte store and component-start stack
    logic [7:0]     store_mem [STORE_BYTES];
    logic [WLW-1:0] stack_mem [MAX_DEPTH];
    logic [7:0]     store_rd_reg;
    logic [WLW-1:0] stack_rd_reg;

    // Path state
    logic [WLW-1:0] wl_reg, wl_b, wl_n;
    logic [1:0]     cl_reg, cl_b, cl_n;
    logic           dots_reg, dots_b, dots_n;
    logic           fin_reg, fin_n;
    logic           ovf_reg, ovf_b, ovf_n;
    logic [DW-1:0]  dep_reg, dep_b, dep_n;
    logic [WLW-1:0] start_reg, start_n;
    logic [WLW-1:0] top_reg, top_n;
    logic [WLW-1:0] nxt_reg, nxt_n, nxt_base;
    logic           pend_reg;

    // Memory access controls
    logic           sw_en;
    logic [AW-1:0]  sw_addr;
    logic [7:0]     sw_data;
    logic           kw_en;
    logic [SAW-1:0] kw_addr;
    logic           kr_en;
    logic [SAW-1:0] kr_addr;
    logic           is_slash, is_dot, end_c;

    // Read request
    logic           rd_hit;
    logic [AW-1:0]  rd_addr;

    // Read stage
    logic           pipe_valid_reg;
    logic           pipe_hit_reg;
    logic           pipe_zero_reg;
    logic [8:0]     pipe_len_reg;
    logic           pipe_done_reg;
    logic           pipe_trunc_reg;
    result_t        pipe_res;

    // Result queue
    result_t        q_mem [3];
    logic [1:0]     q_wr_reg, q_rd_reg, q_cnt_reg;
    logic           q_pop;
    result_t        q_head;

    logic acc, acc_path, acc_read;

    assign acc      = s_valid && s_ready;
    assign acc_path = acc && (s_kind == KIND_PATH);
    assign acc_read = acc && (s_kind == KIND_READ);

    assign is_slash = (s_path_byte == SLASH_CH);
    assign is_dot   = (s_path_byte == DOT_CH);
    assign nxt_base = pend_reg ? stack_rd_reg : nxt_reg;

    // A finished path restarts on its next path byte
    assign wl_b   = fin_reg ? '0 : wl_reg;
    assign cl_b   = fin_reg ? '0 : cl_reg;
    assign dots_b = fin_reg ? 1'b1 : dots_reg;
    assign ovf_b  = fin_reg ? 1'b0 : ovf_reg;
    assign dep_b  = fin_reg ? '0 : dep_reg;

    // Byte position 0 of a non-empty path is always the root slash and is never read
    // from the store. The slash of every later component is written when the previous
    // one closes.
    always_comb begin
        wl_n    = wl_b;
        cl_n    = cl_b;
        dots_n  = dots_b;
        ovf_n   = ovf_b;
        dep_n   = dep_b;
        start_n = start_reg;
        top_n   = top_reg;
        nxt_n   = nxt_base;
        sw_en   = 1'b0;
        sw_addr = '0;
        sw_data = s_path_byte;
        kw_en   = 1'b0;
        kw_addr = '0;
        kr_en   = 1'b0;
        kr_addr = '0;

        if (!ovf_b && !is_slash) begin
            if (cl_b == 2'd0) begin
                if (dep_b >= DEPTH_LIM || ({1'b0, wl_b} + (WLW + 1)'(2)) > STORE_LIM) begin
                    ovf_n = 1'b1;
                end else begin
                    start_n = wl_b;
                    sw_en   = 1'b1;
                    sw_addr = AW'(wl_b + WLW'(1));
                    wl_n    = wl_b + WLW'(2);
                    cl_n    = 2'd1;
                    dots_n  = is_dot;
                end
            end else if (({1'b0, wl_b} + (WLW + 1)'(1)) > STORE_LIM) begin
                ovf_n = 1'b1;
            end else begin
                sw_en   = 1'b1;
                sw_addr = AW'(wl_b);
                wl_n    = wl_b + WLW'(1);
                cl_n    = (cl_b == 2'd3) ? 2'd3 : cl_b + 2'd1;
                dots_n  = dots_b && is_dot;
            end
        end

        end_c = (!ovf_b && is_slash) || s_last;
        if (end_c) begin
            if (cl_n != 2'd0) begin
                if (dots_n && cl_n != 2'd3) begin
                    if (cl_n == 2'd2 && dep_n != '0) begin
                        // "..": drop itself and the name below; prefetch the new second entry
                        wl_n    = top_reg;
                        dep_n   = dep_n - DW'(1);
                        top_n   = nxt_base;
                        kr_en   = (dep_n >= DW'(2));
                        kr_addr = SAW'(dep_n - DW'(2));
                    end else begin
                        wl_n = start_n;
                    end
                end else begin
                    kw_en   = 1'b1;
                    kw_addr = SAW'(dep_n);
                    nxt_n   = top_reg;
                    top_n   = start_n;
                    dep_n   = dep_n + DW'(1);
                end
            end
            cl_n   = 2'd0;
            dots_n = 1'b1;
            if (!ovf_b && is_slash && ({1'b0, wl_n} < STORE_LIM)) begin
                sw_en   = 1'b1;
                sw_addr = AW'(wl_n);
                sw_data = SLASH_CH;
            end
        end

        if (s_last && wl_n == '0) begin
            wl_n = WLW'(1);
        end
        fin_n = s_last;
    end

    assign rd_hit  = CW'(s_read_index) < CW'(wl_reg);
    assign rd_addr = AW'(s_read_index);

    always_ff @(posedge aclk) begin
        if (acc_path && sw_en) begin
            store_mem[sw_addr] <= sw_data;
        end
        if (acc_read && rd_hit) begin
            store_rd_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_path && kw_en) begin
            stack_mem[kw_addr] <= start_n;
        end
        if (acc_path && kr_en) begin
            stack_rd_reg <= stack_mem[kr_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg   <= '0;
            cl_reg   <= '0;
            dots_reg <= 1'b1;
            fin_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            dep_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= acc_path && kr_en;
            if (acc_path) begin
                wl_reg   <= wl_n;
                cl_reg   <= cl_n;
                dots_reg <= dots_n;
                fin_reg  <= fin_n;
                ovf_reg  <= ovf_n;
                dep_reg  <= dep_n;
            end
        end
    end

    // Stack top cache; fold in the prefetched entry as soon as it lands
    always_ff @(posedge aclk) begin
        if (acc_path) begin
            start_reg <= start_n;
            top_reg   <= top_n;
            nxt_reg   <= nxt_n;
        end else begin
            nxt_reg   <= nxt_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
        end else begin
            pipe_valid_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_path) begin
            pipe_hit_reg   <= 1'b0;
            pipe_zero_reg  <= 1'b0;
            pipe_len_reg   <= 9'(wl_n);
            pipe_done_reg  <= fin_n;
            pipe_trunc_reg <= ovf_n;
        end else if (acc_read) begin
            pipe_hit_reg   <= rd_hit;
            pipe_zero_reg  <= (s_read_index == 8'd0);
            pipe_len_reg   <= 9'(wl_reg);
            pipe_done_reg  <= fin_reg;
            pipe_trunc_reg <= ovf_reg;
        end
    end

    always_comb begin
        pipe_res.read_byte   = !pipe_hit_reg ? 8'd0 : (pipe_zero_reg ? SLASH_CH : store_rd_reg);
        pipe_res.path_length = pipe_len_reg;
        pipe_res.done_res    = pipe_done_reg;
        pipe_res.truncated   = pipe_trunc_reg;
    end

    // Room is reserved for the beat in the read stage, so a push never finds the queue full
    assign s_ready = ({1'b0, q_cnt_reg} + {2'b00, pipe_valid_reg}) <= 3'd2;
    assign m_valid = (q_cnt_reg != 2'd0);
    assign q_pop   = m_valid && m_ready;
    assign q_head  = q_mem[q_rd_reg];

    assign m_read_byte   = q_head.read_byte;
    assign m_path_length = q_head.path_length;
    assign m_done_res    = q_head.done_res;
    assign m_truncated   = q_head.truncated;

    always_ff @(posedge aclk) begin
        if (pipe_valid_reg) begin
            q_mem[q_wr_reg] <= pipe_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            if (pipe_valid_reg) begin
                q_wr_reg <= (q_wr_reg == 2'd2) ? 2'd0 : q_wr_reg + 2'd1;
            end
            if (q_pop) begin
                q_rd_reg <= (q_rd_reg == 2'd2) ? 2'd0 : q_rd_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, pipe_valid_reg} - {1'b0, q_pop};
        end
    end

endmodule

// ===== hw/rtl/lpn_checker.sv =====
// Port-level checks for the lexical path normalizer, bound to its top level.
// Depends on lpn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpn_checker
    import lpn_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_byte,
    input logic [8:0] m_path_length,
    input logic       m_done_res,
    input logic       m_truncated
);

    // Hold the result beat while the receiver stalls
    `LPN_ASSERT(a_out_hold, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_byte) &&
        $stable(m_path_length) && $stable(m_done_res) && $stable(m_truncated)))

    // A finished path is never empty: at least the root slash
    `LPN_IMPLY(a_done_nonempty, aclk, aresetn, m_valid && m_done_res,
        (STORE_BYTES > 511) || (m_path_length != 9'd0))

    // The length never exceeds the store
    `LPN_IMPLY(a_len_bound, aclk, aresetn, m_valid,
        (STORE_BYTES > 511) || (m_path_length <= 9'(STORE_BYTES)))

    // A nonzero byte can only come from inside the current path
    `LPN_IMPLY(a_read_in_len, aclk, aresetn, m_valid && (m_read_byte != 8'd0),
        (STORE_BYTES > 511) || (m_path_length != 9'd0))

endmodule

bind lexical_path_normalizer_top lpn_checker #(.STORE_BYTES(STORE_BYTES)) u_lpn_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_read_byte   (m_read_byte),
    .m_path_length (m_path_length),
    .m_done_res    (m_done_res),
    .m_truncated   (m_truncated)
);

// ===== bench/lexical_path_normalizer_top_test.sv =====
// Self-checking bench for lexical_path_normalizer_top: random valid/ready traffic on both sides,
// results predicted beat by beat and compared in a scoreboard class.
// Depends on lpn_pkg and the lexical_path_normalizer_top RTL.
module lexical_path_normalizer_top_test;
    import lpn_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int STALL_PCT    = 27;
    localparam int RANDOM_BEATS = 1850;
    localparam int HANG_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 8;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0] read_byte;
        logic [8:0] path_length;
        logic       done_res;
        logic       truncated;
    } norm_result_t;

    typedef enum {SHAPE_TIDY, SHAPE_DEEP, SHAPE_LONG, SHAPE_NOISE} path_shape_t;

    class path_scoreboard;
        logic [7:0]   store_img [STORE_BYTES_DEF];
        logic [8:0]   starts_img [MAX_DEPTH_DEF];
        int unsigned  depth;
        int unsigned  wr_len;
        int unsigned  comp_len;
        bit           dots;
        bit           done;
        bit           trunc;
        norm_result_t pending_results[$];
        int           beats_taken;
        int           reads_taken;
        int           paths_closed;
        int           paths_cut;
        int           results_checked;
        int           errors;

        function new();
            restart();
            beats_taken     = 0;
            reads_taken     = 0;
            paths_closed    = 0;
            paths_cut       = 0;
            results_checked = 0;
            errors          = 0;
        endfunction

        function void restart();
            depth    = 0;
            wr_len   = 0;
            comp_len = 0;
            dots     = 1'b1;
            done     = 1'b0;
            trunc    = 1'b0;
        endfunction

        // Close the component in progress: drop ".", pop one more level for "..".
        function void close_component();
            if (comp_len != 0 && dots && comp_len <= 2 && depth > 0) begin
                depth--;
                wr_len = starts_img[depth];
                if (comp_len == 2 && depth > 0) begin
                    depth--;
                    wr_len = starts_img[depth];
                end
            end
            comp_len = 0;
            dots     = 1'b1;
        endfunction

        function void absorb_char(logic [7:0] b);
            if (trunc)
                return;
            if (b == SLASH_CH) begin
                close_component();
                return;
            end
            if (comp_len == 0) begin
                if (depth >= MAX_DEPTH_DEF || wr_len + 2 > STORE_BYTES_DEF) begin
                    trunc = 1'b1;
                    return;
                end
                starts_img[depth] = 9'(wr_len);
                depth++;
                store_img[wr_len] = SLASH_CH;
                wr_len++;
            end else if (wr_len + 1 > STORE_BYTES_DEF) begin
                trunc = 1'b1;
                return;
            end
            store_img[wr_len] = b;
            wr_len++;
            comp_len++;
            dots = dots && (b == DOT_CH);
        endfunction

        function void take_input_beat(logic k, logic [7:0] b, logic l, logic [7:0] idx);
            norm_result_t r;
            r = '0;
            beats_taken++;
            if (k == KIND_PATH) begin
                if (done)
                    restart();
                absorb_char(b);
                if (l) begin
                    close_component();
                    if (wr_len == 0) begin
                        store_img[0] = SLASH_CH;
                        wr_len = 1;
                    end
                    done = 1'b1;
                    paths_closed++;
                    if (trunc)
                        paths_cut++;
                end
            end else begin
                reads_taken++;
                if (idx < wr_len)
                    r.read_byte = store_img[idx];
            end
            r.path_length = 9'(wr_len);
            r.done_res    = done;
            r.truncated   = trunc;
            pending_results.push_back(r);
        endfunction

        function void check_result_beat(logic [7:0] rb, logic [8:0] len, logic dn, logic tr);
            norm_result_t want;
            results_checked++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing outstanding: path_length %0d", len);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (rb !== want.read_byte) begin
                $error("read_byte: expected %0d, got %0d", want.read_byte, rb);
                errors++;
            end
            if (len !== want.path_length) begin
                $error("path_length: expected %0d, got %0d", want.path_length, len);
                errors++;
            end
            if (dn !== want.done_res) begin
                $error("done_res: expected %0d, got %0d", want.done_res, dn);
                errors++;
            end
            if (tr !== want.truncated) begin
                $error("truncated: expected %0d, got %0d", want.truncated, tr);
                errors++;
            end
        endfunction

        function void flag_leftovers();
            if (pending_results.size() != 0) begin
                $error("%0d result beats never arrived", pending_results.size());
                errors += pending_results.size();
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic       s_kind       = KIND_PATH;
    logic [7:0] s_path_byte  = 8'h00;
    logic       s_last       = 1'b0;
    logic [7:0] s_read_index = 8'h00;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_read_byte;
    logic [8:0] m_path_length;
    logic       m_done_res;
    logic       m_truncated;

    bit             calm = 1'b0;
    int             beats_sent = 0;
    int             quiet_cycles = 0;
    path_scoreboard sb = new();

    lexical_path_normalizer_top #(
        .STORE_BYTES(STORE_BYTES_DEF),
        .MAX_DEPTH  (MAX_DEPTH_DEF)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_path_byte  (s_path_byte),
        .s_last       (s_last),
        .s_read_index (s_read_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_byte  (m_read_byte),
        .m_path_length(m_path_length),
        .m_done_res   (m_done_res),
        .m_truncated  (m_truncated)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Sample pre-edge values of both channels; watch for a hung pipeline.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result_beat(m_read_byte, m_path_length, m_done_res, m_truncated);
            if (s_valid && s_ready)
                sb.take_input_beat(s_kind, s_path_byte, s_last, s_read_index);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", HANG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic k, input logic [7:0] b, input logic l,
                             input logic [7:0] idx);
        while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= k;
        s_path_byte  <= b;
        s_last       <= l;
        s_read_index <= idx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
    endtask

    // Hold the sender off until every outstanding result has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_index();
        int hi;
        hi = sb.wr_len + 1;
        if (hi > 255)
            hi = 255;
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, hi));
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0, 1:    c = DOT_CH;
            2:       c = 8'h00;
            3:       c = 8'hFF;
            default: c = 8'($urandom);
        endcase
        if (c == SLASH_CH)
            c = 8'h5F;
        return c;
    endfunction

    function automatic void build_path(input path_shape_t shape, output byte_q_t q);
        int n;
        int pick;
        q = {};
        case (shape)
            SHAPE_DEEP: begin
                // Plain one-letter names around the stack limit; no dots so none pop.
                n = $urandom_range(MAX_DEPTH_DEF - 1, MAX_DEPTH_DEF + 3);
                repeat (n) begin
                    q.push_back(SLASH_CH);
                    q.push_back(8'($urandom_range(8'h30, 8'h7A)));
                end
            end
            SHAPE_LONG: begin
                while (q.size() < STORE_BYTES_DEF + 8) begin
                    q.push_back(SLASH_CH);
                    repeat ($urandom_range(20, 90))
                        q.push_back(name_char());
                end
                if ($urandom_range(0, 1) == 1) begin
                    q.push_back(SLASH_CH);
                    q.push_back(DOT_CH);
                    q.push_back(DOT_CH);
                end
            end
            SHAPE_NOISE: begin
                repeat ($urandom_range(1, 16)) begin
                    pick = $urandom_range(0, 9);
                    q.push_back(pick < 3 ? SLASH_CH : pick < 6 ? DOT_CH : 8'($urandom));
                end
            end
            default: begin
                repeat ($urandom_range(0, 2))
                    q.push_back(SLASH_CH);
                n = $urandom_range(0, 7);
                for (int i = 0; i < n; i++) begin
                    if (i > 0)
                        repeat ($urandom_range(1, 3))
                            q.push_back(SLASH_CH);
                    case ($urandom_range(0, 9))
                        0: q.push_back(DOT_CH);
                        1, 2: begin
                            q.push_back(DOT_CH);
                            q.push_back(DOT_CH);
                        end
                        3: repeat ($urandom_range(3, 4))
                            q.push_back(DOT_CH);
                        default: repeat ($urandom_range(1, 8))
                            q.push_back(name_char());
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                    q.push_back(SLASH_CH);
            end
        endcase
        if (q.size() == 0)
            q.push_back($urandom_range(0, 1) == 1 ? SLASH_CH : DOT_CH);
    endfunction

    task automatic send_path(input byte_q_t chars, input int read_pct);
        for (int i = 0; i < chars.size(); i++) begin
            if ($urandom_range(0, 99) < read_pct)
                send_beat(KIND_READ, 8'($urandom), 1'($urandom), pick_index());
            send_beat(KIND_PATH, chars[i], i == chars.size() - 1, 8'($urandom));
        end
    endtask

    initial begin
        byte_q_t     chars;
        path_shape_t shape;
        int          roll;
        int          npaths;
        int          first_random;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reads on an empty store, root-only paths, dot names, zero and 0xFF bytes.
        send_beat(KIND_READ, 8'h00, 1'b0, 8'h00);
        send_beat(KIND_READ, 8'hFF, 1'b1, 8'hFF);
        chars = {SLASH_CH};
        send_path(chars, 0);
        chars = {DOT_CH, DOT_CH};
        send_path(chars, 0);
        chars = {8'h00, SLASH_CH, DOT_CH, DOT_CH, DOT_CH, SLASH_CH, 8'hFF, SLASH_CH,
                 DOT_CH, DOT_CH};
        send_path(chars, 0);
        send_beat(KIND_READ, 8'h5A, 1'b0, 8'd1);
        send_beat(KIND_READ, 8'hA5, 1'b1, 8'd5);
        send_beat(KIND_READ, 8'h00, 1'b0, 8'd6);
        chars = {SLASH_CH, SLASH_CH, 8'h78, SLASH_CH, DOT_CH, SLASH_CH};
        send_path(chars, 0);
        hold_until_drained();

        npaths       = 0;
        first_random = beats_sent;
        while (beats_sent - first_random < RANDOM_BEATS) begin
            calm  = (beats_sent - first_random >= 700) && (beats_sent - first_random < 1000);
            roll  = $urandom_range(0, 99);
            shape = npaths == 0 ? SHAPE_LONG :
                    npaths == 1 ? SHAPE_DEEP :
                    roll < 5    ? SHAPE_LONG :
                    roll < 10   ? SHAPE_DEEP :
                    roll < 22   ? SHAPE_NOISE : SHAPE_TIDY;
            build_path(shape, chars);
            send_path(chars, 15);
            repeat ($urandom_range(0, 3))
                send_beat(KIND_READ, 8'($urandom), 1'($urandom), pick_index());
            if ($urandom_range(0, 11) == 0)
                hold_until_drained();
            npaths++;
        end
        calm = 1'b0;

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        sb.flag_leftovers();

        $display("Sent %0d beats: %0d reads, %0d paths closed, %0d of them truncated.",
                 sb.beats_taken, sb.reads_taken, sb.paths_closed, sb.paths_cut);
        $display("Compared %0d result beats, %0d mismatches.", sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== lexical_path_normalizer_top.f =====
+incdir+hw/rtl
hw/rtl/lpn_pkg.sv
hw/rtl/lexical_path_normalizer_top.sv
hw/rtl/lpn_checker.sv
bench/lexical_path_normalizer_top_test.sv
